FILE: design/bcdtmr_pkg.sv
// ----------------------------------------------------------------------------
// bcdtmr_pkg: shared types and constants
// Field widths, action codes and the controller/datapath command bundle for
// the BCD up/down minute timer.
// ----------------------------------------------------------------------------
`default_nettype none

package bcdtmr_pkg;

   localparam int ACTION_W = 2;
   localparam int BUTTON_W = 3;
   localparam int TENS_W   = 3;
   localparam int ONES_W   = 4;
   localparam int PCT_W    = 7;
   localparam int TIME_W   = 12;
   localparam int PROD_W   = TIME_W + PCT_W;   // elapsed * 100

   localparam int ONES_TOP       = 9;
   localparam int TENS_TOP       = 5;
   localparam int TICKS_PER_STEP = 60;
   localparam int PCT_FULL       = 100;

   // one quotient bit per step; percent below 100 fits in PCT_W bits
   localparam int DIV_STEPS = PCT_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   typedef enum logic [ACTION_W-1:0] {
      ACT_ADJUST = 2'd0,
      ACT_TOGGLE = 2'd1,
      ACT_RESET  = 2'd2,
      ACT_TICK   = 2'd3
   } action_type;

   // upper two button bits pick the digit, bit 0 picks the direction
   typedef enum logic [1:0] {
      TGT_RIGHT_ONES = 2'd0,
      TGT_RIGHT_TENS = 2'd1,
      TGT_LEFT_ONES  = 2'd2,
      TGT_LEFT_TENS  = 2'd3
   } target_type;

   typedef struct packed {
      logic update;     // apply accepted transaction to timer state
      logic div_init;   // load divider operands
      logic div_step;   // one quotient bit
      logic load_out;   // capture result into output register
   } ctl_cmd_type;

   typedef struct packed {
      logic out_free;   // output register empty or being drained
   } dp_status_type;

endpackage : bcdtmr_pkg

`default_nettype wire

FILE: design/bcdtmr_if.sv
// ----------------------------------------------------------------------------
// bcdtmr_if: channel interfaces
// Valid/ready request and response channels of the minute timer.
// ----------------------------------------------------------------------------
`default_nettype none

interface bcdtmr_req_if;
   import bcdtmr_pkg::*;

   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [BUTTON_W-1:0] button;

   modport source (output valid, action, button, input ready);
   modport sink   (input valid, action, button, output ready);
endinterface : bcdtmr_req_if

interface bcdtmr_rsp_if;
   import bcdtmr_pkg::*;

   logic              valid;
   logic              ready;
   logic [TENS_W-1:0] left_tens;
   logic [ONES_W-1:0] left_ones;
   logic [TENS_W-1:0] right_tens;
   logic [ONES_W-1:0] right_ones;
   logic              is_running;
   logic [PCT_W-1:0]  progress_percent;
   logic              expired;

   modport source (output valid, left_tens, left_ones, right_tens, right_ones,
                   is_running, progress_percent, expired, input ready);
   modport sink   (input valid, left_tens, left_ones, right_tens, right_ones,
                   is_running, progress_percent, expired, output ready);
endinterface : bcdtmr_rsp_if

`default_nettype wire

FILE: design/bcd_up_down_minute_timer.sv
// A response is valid once its request transaction has passed the INIT, DIV
//   and OUT states. A new request is taken only back in IDLE, after the
//   7-step restoring divider for the progress percentage and the output load.
// A pending response does not block the next request: the output register
//   holds it while the next transaction is worked.
// Reset (synchronous, active high): timer cleared to 00:00, stopped, count-up.
// ----------------------------------------------------------------------------
// bcd_up_down_minute_timer: four-digit BCD mm:ss timer
// Adjust, start/stop, reset and one-second tick transactions update the
// displayed digits; each transaction returns one response with the digits,
// run state, progress ring percentage and expiry flag.
// ----------------------------------------------------------------------------
`default_nettype none

module bcd_up_down_minute_timer (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     csr_we,      // mode register write strobe
   input  wire logic     csr_wdata,   // 1 = count down, 0 = count up
   bcdtmr_req_if.sink    req,
   bcdtmr_rsp_if.source  rsp
);
   import bcdtmr_pkg::*;

   ctl_cmd_type   cmd;
   dp_status_type status;

   // Controller: IDLE takes a transaction, INIT loads the divider,
   // DIV runs one quotient bit per cycle, OUT waits for the output register.
   bcdtmr_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .req    (req),
      .status (status),
      .cmd    (cmd)
   );

   // Datapath: the whole state update happens at the accepting edge, the
   // divider then works on the updated elapsed count.
   bcdtmr_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_action (req.action),
      .req_button (req.button),
      .cmd        (cmd),
      .status     (status),
      .rsp        (rsp)
   );

   // ------------------------------------------------------------ assertions
   // one transaction in flight: ready drops right after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> !req.ready)
      else $error("request accepted while previous one in progress");

   // progress ring never beyond full scale
   a_pct_range: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.progress_percent <= PCT_W'(PCT_FULL)))
      else $error("progress percent above 100");

   // expiry always stops the timer
   a_expired_stops: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.expired) |-> !rsp.is_running)
      else $error("expired response shows running timer");

   // BCD digits stay in range
   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.left_tens <= TENS_W'(TENS_TOP)
                  && rsp.right_tens <= TENS_W'(TENS_TOP)
                  && rsp.left_ones <= ONES_W'(ONES_TOP)
                  && rsp.right_ones <= ONES_W'(ONES_TOP)))
      else $error("digit out of BCD range");

endmodule : bcd_up_down_minute_timer

`default_nettype wire

FILE: design/bcdtmr_ctrl.sv
// ----------------------------------------------------------------------------
// bcdtmr_ctrl: sequencing controller
// Accepts a transaction, then steps the datapath through divider setup,
// the quotient bits and the output load.
// ----------------------------------------------------------------------------
`default_nettype none

module bcdtmr_ctrl (
   input  wire logic                      clock,
   input  wire logic                      reset,
   bcdtmr_req_if.sink                     req,
   input  wire bcdtmr_pkg::dp_status_type status,
   output bcdtmr_pkg::ctl_cmd_type        cmd
);
   import bcdtmr_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_INIT = 4'b0010,
      ST_DIV  = 4'b0100,
      ST_OUT  = 4'b1000
   } state_type;

   state_type            state_ff, state_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 last_step;

   assign req.ready = (state_ff == ST_IDLE);
   assign last_step = (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1));

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               cmd.update = 1'b1;
               state_in   = ST_INIT;
            end
         end
         ST_INIT: begin
            cmd.div_init = 1'b1;
            cnt_in       = '0;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (last_step) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule : bcdtmr_ctrl

`default_nettype wire

FILE: design/bcdtmr_dp.sv
// ----------------------------------------------------------------------------
// bcdtmr_dp: timer datapath
// Digit registers, counters, mode register, restoring percent divider and
// the response output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bcdtmr_dp (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_we,
   input  wire logic                                csr_wdata,
   input  wire logic [bcdtmr_pkg::ACTION_W-1:0]     req_action,
   input  wire logic [bcdtmr_pkg::BUTTON_W-1:0]     req_button,
   input  wire bcdtmr_pkg::ctl_cmd_type             cmd,
   output bcdtmr_pkg::dp_status_type                status,
   bcdtmr_rsp_if.source                             rsp
);
   import bcdtmr_pkg::*;

   typedef struct packed {
      logic [TENS_W-1:0] lt;
      logic [ONES_W-1:0] lo;
      logic [TENS_W-1:0] rt;
      logic [ONES_W-1:0] ro;
   } digits_type;

   typedef struct packed {
      logic              wrap;
      logic [ONES_W-1:0] value;
   } step_type;

   function automatic step_type step_digit(logic [ONES_W-1:0] d,
                                           logic [ONES_W-1:0] top,
                                           logic down);
      step_type s;
      s.wrap  = 1'b0;
      s.value = d;
      if (down) begin
         if (d == '0) begin
            s.value = top;
            s.wrap  = 1'b1;
         end else begin
            s.value = d - 1'b1;
         end
      end else begin
         if (d >= top) begin
            s.value = '0;
            s.wrap  = 1'b1;
         end else begin
            s.value = d + 1'b1;
         end
      end
      return s;
   endfunction

   function automatic digits_type ripple(digits_type d, logic down);
      digits_type r;
      step_type   s;
      r      = d;
      s      = step_digit(d.ro, ONES_W'(ONES_TOP), down);
      r.ro   = s.value;
      if (s.wrap) begin
         s    = step_digit(ONES_W'(d.rt), ONES_W'(TENS_TOP), down);
         r.rt = s.value[TENS_W-1:0];
         if (s.wrap) begin
            s    = step_digit(d.lo, ONES_W'(ONES_TOP), down);
            r.lo = s.value;
            if (s.wrap) begin
               s    = step_digit(ONES_W'(d.lt), ONES_W'(TENS_TOP), down);
               r.lt = s.value[TENS_W-1:0];
            end
         end
      end
      return r;
   endfunction

   function automatic logic [TIME_W-1:0] to_seconds(digits_type d);
      return TIME_W'(d.lt) * TIME_W'(600) + TIME_W'(d.lo) * TIME_W'(60)
           + TIME_W'(d.rt) * TIME_W'(10) + TIME_W'(d.ro);
   endfunction

   // timer state
   digits_type        dig_ff, dig_in;
   logic              running_ff, running_in;
   logic [TIME_W-1:0] total_ff, total_in;
   logic [TIME_W-1:0] elapsed_ff, elapsed_in;
   logic              expired_ff, expired_in;
   logic              cd_ff;

   // divider
   logic [TIME_W-1:0] den_ff;
   logic [TIME_W-1:0] rem_ff;
   logic [PCT_W-1:0]  num_lo_ff;
   logic [PCT_W-1:0]  quo_ff;
   logic              zero_ff;
   logic              sat_ff;
   logic [PROD_W-1:0] product;
   logic [TIME_W-1:0] den_sel;
   logic [TIME_W:0]   trial;
   logic              fits;

   // output register
   logic              rsp_valid_ff;
   logic [PCT_W-1:0]  pct_ff;
   digits_type        out_dig_ff;
   logic              out_run_ff;
   logic              out_exp_ff;
   logic [PCT_W-1:0]  pct_result;

   // ---------------------------------------------------------------- update
   always_comb begin
      logic [TIME_W-1:0] elapsed_inc;
      logic              down;
      logic              do_clear;
      step_type          s;
      dig_in      = dig_ff;
      running_in  = running_ff;
      total_in    = total_ff;
      elapsed_in  = elapsed_ff;
      expired_in  = expired_ff;
      do_clear    = 1'b0;
      down        = req_button[0];
      s           = '0;
      elapsed_inc = (elapsed_ff == '1) ? elapsed_ff : elapsed_ff + 1'b1;
      if (cmd.update) begin
         expired_in = 1'b0;
         case (action_type'(req_action))
            ACT_ADJUST: begin
               if (!running_ff) begin
                  case (target_type'(req_button[2:1]))
                     TGT_RIGHT_ONES: begin
                        s         = step_digit(dig_ff.ro, ONES_W'(ONES_TOP), down);
                        dig_in.ro = s.value;
                     end
                     TGT_RIGHT_TENS: begin
                        s         = step_digit(ONES_W'(dig_ff.rt), ONES_W'(TENS_TOP),
                                               down);
                        dig_in.rt = s.value[TENS_W-1:0];
                     end
                     TGT_LEFT_ONES: begin
                        s         = step_digit(dig_ff.lo, ONES_W'(ONES_TOP), down);
                        dig_in.lo = s.value;
                     end
                     default: begin
                        s         = step_digit(ONES_W'(dig_ff.lt), ONES_W'(TENS_TOP),
                                               down);
                        dig_in.lt = s.value[TENS_W-1:0];
                     end
                  endcase
                  total_in = to_seconds(dig_in);
               end
            end
            ACT_TOGGLE: begin
               if (running_ff) begin
                  running_in = 1'b0;
               end else if (!(cd_ff && total_ff == '0)) begin
                  running_in = 1'b1;
               end
            end
            ACT_RESET: begin
               do_clear = 1'b1;
            end
            default: begin
               if (running_ff) begin
                  if (!cd_ff) begin
                     total_in = TIME_W'(TICKS_PER_STEP);
                     if (elapsed_inc >= TIME_W'(TICKS_PER_STEP)) begin
                        dig_in     = ripple(dig_ff, 1'b0);
                        elapsed_in = '0;
                     end else begin
                        elapsed_in = elapsed_inc;
                     end
                  end else begin
                     dig_in     = ripple(dig_ff, 1'b1);
                     elapsed_in = elapsed_inc;
                     if (elapsed_inc >= total_ff) begin
                        expired_in = 1'b1;
                        do_clear   = 1'b1;
                     end
                  end
               end
            end
         endcase
         if (do_clear) begin
            dig_in     = '0;
            running_in = 1'b0;
            total_in   = '0;
            elapsed_in = '0;
            if (cd_ff) begin
               dig_in.lo = ONES_W'(1);
               total_in  = TIME_W'(TICKS_PER_STEP);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dig_ff     <= '0;
         running_ff <= 1'b0;
         total_ff   <= '0;
         elapsed_ff <= '0;
         expired_ff <= 1'b0;
         cd_ff      <= 1'b0;
      end else begin
         dig_ff     <= dig_in;
         running_ff <= running_in;
         total_ff   <= total_in;
         elapsed_ff <= elapsed_in;
         expired_ff <= expired_in;
         if (csr_we) begin
            cd_ff <= csr_wdata;
         end
      end
   end

   // --------------------------------------------------------------- divider
   // below saturation elapsed < den, so elapsed*100/den < 100 fits PCT_W bits
   assign den_sel = cd_ff ? total_ff : TIME_W'(TICKS_PER_STEP);
   assign product = PROD_W'(elapsed_ff) * PROD_W'(PCT_FULL);
   assign trial   = {rem_ff, num_lo_ff[PCT_W-1]};
   assign fits    = (trial >= {1'b0, den_ff});

   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         den_ff    <= den_sel;
         rem_ff    <= product[PROD_W-1:PCT_W];
         num_lo_ff <= product[PCT_W-1:0];
         quo_ff    <= '0;
         zero_ff   <= (den_sel == '0);
         sat_ff    <= (elapsed_ff >= den_sel);
      end else if (cmd.div_step) begin
         rem_ff    <= fits ? TIME_W'(trial - {1'b0, den_ff}) : trial[TIME_W-1:0];
         num_lo_ff <= {num_lo_ff[PCT_W-2:0], 1'b0};
         quo_ff    <= {quo_ff[PCT_W-2:0], fits};
      end
   end

   assign pct_result = zero_ff ? '0 : (sat_ff ? PCT_W'(PCT_FULL) : quo_ff);

   // ------------------------------------------------------------ output reg
   assign status.out_free = !rsp_valid_ff || rsp.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_dig_ff <= dig_ff;
         out_run_ff <= running_ff;
         out_exp_ff <= expired_ff;
         pct_ff     <= pct_result;
      end
   end

   assign rsp.valid            = rsp_valid_ff;
   assign rsp.left_tens        = out_dig_ff.lt;
   assign rsp.left_ones        = out_dig_ff.lo;
   assign rsp.right_tens       = out_dig_ff.rt;
   assign rsp.right_ones       = out_dig_ff.ro;
   assign rsp.is_running       = out_run_ff;
   assign rsp.progress_percent = pct_ff;
   assign rsp.expired          = out_exp_ff;

endmodule : bcdtmr_dp

`default_nettype wire
